>>> design/ffpa_pkg.sv
// Shared types, constants and width helpers of the first-fit pool allocator.
package ffpa_pkg;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned REQ_W    = 10;
    localparam int unsigned OFF_W    = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned GAP_W    = 7;
    localparam int unsigned PAD_W    = 32;

    localparam int unsigned DEF_POOL_BYTES   = 1024;
    localparam int unsigned DEF_HEADER_BYTES = 16;

    // Requests are rounded up to a multiple of 2**ALIGN_W bytes.
    localparam int unsigned ALIGN_W     = 2;
    localparam int unsigned ALIGN_BYTES = 1 << ALIGN_W;

    localparam logic [GAP_W-1:0] GAP_MAX = '1;
    localparam logic [PAD_W-1:0] PAD_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_GAPS  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_NULL    = 2'd2,
        ST_BADADDR = 2'd3
    } t_status;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_PREP,
        S_LOOP,
        S_CHK,
        S_NXT1,
        S_NXT2,
        S_SPL1,
        S_SPL2,
        S_SPL3,
        S_SPL4,
        S_ACOM,
        S_FM1,
        S_FM2,
        S_FM3,
        S_FM4,
        S_FM5,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd             cmd;
        logic [REQ_W-1:0] request_size;
        logic [OFF_W-1:0] payload_offset;
        logic             is_null;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] granted_offset;
        logic [GAP_W-1:0] gap_count;
        logic [PAD_W-1:0] padding_total;
    } t_out_item;

    typedef struct packed {
        t_status            status;
        logic [OFF_W-1:0]   granted;
        logic [GAP_W-1:0]   gaps;
        logic [ALIGN_W-1:0] pad_add;
    } t_ctrl_res;

    function automatic int unsigned f_addr_w(input int unsigned pool);
        return $clog2(pool);
    endfunction

    // Width of the shared arithmetic unit: holds pool positions up to the pool size
    // and rounded requests plus a header, with one spare bit.
    function automatic int unsigned f_calc_w(input int unsigned pool);
        int unsigned w;
        w = ($clog2(pool) + 1 > REQ_W + 1) ? $clog2(pool) + 1 : REQ_W + 1;
        return w + 1;
    endfunction

endpackage

>>> design/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
    parameter int unsigned WIDTH = 11,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ffpa_alu.sv
// Shared add/subtract unit; a subtract also reports whether a is below b.
module ffpa_alu import ffpa_pkg::*; #(
    parameter int unsigned WIDTH = 13
) (
    input  t_alu_op          i_op,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_res,
    output logic             o_lt
);

    logic [WIDTH:0] w_sum;

    always_comb begin
        unique case (i_op)
            ALU_ADD: w_sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_sum = {1'b0, i_a} - {1'b0, i_b};
            default: w_sum = '0;
        endcase
    end

    assign o_res = w_sum[WIDTH-1:0];
    // The borrow out of a subtract is set exactly when a < b.
    assign o_lt  = (i_op == ALU_SUB) && w_sum[WIDTH];

endmodule

>>> design/ffpa_ctrl.sv
// Sequencer that walks the header chain and drives the shared ALU and header RAM.
module ffpa_ctrl import ffpa_pkg::*; #(
    parameter int unsigned POOL_BYTES   = DEF_POOL_BYTES,
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
    localparam int unsigned AW = f_addr_w(POOL_BYTES),
    localparam int unsigned WW = f_calc_w(POOL_BYTES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_in_item        i_item,
    output logic            o_idle,
    output logic            o_done,
    input  logic            i_take,
    output t_ctrl_res       o_res,
    output t_alu_op         o_alu_op,
    output logic [WW-1:0]   o_alu_a,
    output logic [WW-1:0]   o_alu_b,
    input  logic [WW-1:0]   i_alu_res,
    input  logic            i_alu_lt,
    output logic            o_mem_wr_en,
    output logic [AW-1:0]   o_mem_wr_addr,
    output logic [AW:0]     o_mem_wr_data,
    output logic            o_mem_rd_en,
    output logic [AW-1:0]   o_mem_rd_addr,
    input  logic [AW:0]     i_mem_rd_data
);

    localparam logic [WW-1:0] POOL_V     = WW'(POOL_BYTES);
    localparam logic [WW-1:0] HDR_V      = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] ALIGN_ADD  = WW'(ALIGN_BYTES - 1);
    localparam logic [WW-1:0] ALIGN_MASK = ~WW'(ALIGN_BYTES - 1);
    localparam logic [AW-1:0] ROOT_SIZE  = AW'(POOL_BYTES - HEADER_BYTES);

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [REQ_W-1:0] r_req, n_req;
    logic [OFF_W-1:0] r_off, n_off;
    logic             r_null, n_null;
    logic [WW-1:0]    r_thr, n_thr;     // rounded request, gap limit or free target
    logic [WW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_size, n_size;
    logic [WW-1:0]    r_tmp, n_tmp;
    logic [WW-1:0]    r_np, n_np;
    logic [AW-1:0]    r_nsize, n_nsize;
    logic             r_nfree, n_nfree;
    logic             r_split, n_split;
    logic [GAP_W-1:0] r_gaps, n_gaps;
    t_ctrl_res        r_res, n_res;

    logic             w_rd_free;
    logic [AW-1:0]    w_rd_size;

    assign w_rd_free = i_mem_rd_data[AW];
    assign w_rd_size = i_mem_rd_data[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_req   <= n_req;
        r_off   <= n_off;
        r_null  <= n_null;
        r_thr   <= n_thr;
        r_pos   <= n_pos;
        r_size  <= n_size;
        r_tmp   <= n_tmp;
        r_np    <= n_np;
        r_nsize <= n_nsize;
        r_nfree <= n_nfree;
        r_split <= n_split;
        r_gaps  <= n_gaps;
        r_res   <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_req   = r_req;
        n_off   = r_off;
        n_null  = r_null;
        n_thr   = r_thr;
        n_pos   = r_pos;
        n_size  = r_size;
        n_tmp   = r_tmp;
        n_np    = r_np;
        n_nsize = r_nsize;
        n_nfree = r_nfree;
        n_split = r_split;
        n_gaps  = r_gaps;
        n_res   = r_res;

        o_alu_op      = ALU_ADD;
        o_alu_a       = r_pos;
        o_alu_b       = '0;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_pos[AW-1:0];
        o_mem_wr_data = '0;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_pos[AW-1:0];

        unique case (r_state)
            S_INIT: begin
                // The pool starts as one free block at offset zero.
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = '0;
                o_mem_wr_data = {1'b1, ROOT_SIZE};
                n_state       = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_item.cmd;
                    n_req   = i_item.request_size;
                    n_off   = i_item.payload_offset;
                    n_null  = i_item.is_null;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_pos   = '0;
                n_gaps  = '0;
                n_split = 1'b0;
                n_res   = '{status: ST_OK, granted: '0, gaps: '0, pad_add: '0};
                case (r_cmd)
                    CMD_ALLOC: begin
                        o_alu_a = WW'(r_req);
                        o_alu_b = ALIGN_ADD;
                        n_thr   = i_alu_res & ALIGN_MASK;
                        n_state = S_LOOP;
                    end
                    CMD_GAPS: begin
                        o_alu_a = WW'(r_req);
                        o_alu_b = HDR_V;
                        n_thr   = i_alu_res;
                        n_state = S_LOOP;
                    end
                    CMD_FREE: begin
                        o_alu_op = ALU_SUB;
                        o_alu_a  = WW'(r_off);
                        o_alu_b  = HDR_V;
                        if (r_null) begin
                            n_res.status = ST_NULL;
                            n_state      = S_DONE;
                        end else if (i_alu_lt) begin
                            n_res.status = ST_BADADDR;
                            n_state      = S_DONE;
                        end else begin
                            n_thr   = i_alu_res;
                            n_state = S_LOOP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_LOOP: begin
                o_alu_op = ALU_SUB;
                o_alu_a  = r_pos;
                o_alu_b  = POOL_V;
                if (i_alu_lt) begin
                    o_mem_rd_en = 1'b1;
                    n_state     = S_CHK;
                end else begin
                    case (r_cmd)
                        CMD_ALLOC: n_res.status = ST_NOFIT;
                        CMD_FREE:  n_res.status = ST_BADADDR;
                        default:   n_res.gaps   = r_gaps;
                    endcase
                    n_state = S_DONE;
                end
            end
            S_CHK: begin
                n_size   = w_rd_size;
                o_alu_op = ALU_SUB;
                case (r_cmd)
                    CMD_ALLOC: begin
                        o_alu_a = WW'(w_rd_size);
                        o_alu_b = r_thr;
                        n_state = (w_rd_free && !i_alu_lt) ? S_SPL1 : S_NXT1;
                    end
                    CMD_GAPS: begin
                        o_alu_a = WW'(w_rd_size);
                        o_alu_b = r_thr;
                        if (w_rd_free && i_alu_lt && (r_gaps != GAP_MAX)) begin
                            n_gaps = r_gaps + 1'b1;
                        end
                        n_state = S_NXT1;
                    end
                    CMD_FREE: begin
                        o_alu_a = r_pos;
                        o_alu_b = r_thr;
                        if (i_alu_res == '0) begin
                            n_state = S_FM1;
                        end else if (!i_alu_lt) begin
                            // The walk passed the address: it is not a block start.
                            n_res.status = ST_BADADDR;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_NXT1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NXT1: begin
                o_alu_a = r_pos;
                o_alu_b = WW'(r_size);
                n_pos   = i_alu_res;
                n_state = S_NXT2;
            end
            S_NXT2: begin
                o_alu_a = r_pos;
                o_alu_b = HDR_V;
                n_pos   = i_alu_res;
                n_state = S_LOOP;
            end
            S_SPL1: begin
                o_alu_a = r_thr;
                o_alu_b = HDR_V;
                n_tmp   = i_alu_res;
                n_state = S_SPL2;
            end
            S_SPL2: begin
                // Split only when the remainder is larger than one header.
                o_alu_op = ALU_SUB;
                o_alu_a  = r_tmp;
                o_alu_b  = WW'(r_size);
                n_state  = i_alu_lt ? S_SPL3 : S_ACOM;
            end
            S_SPL3: begin
                // The split point lies inside this block, so it is always within the pool.
                o_alu_a = r_pos;
                o_alu_b = r_tmp;
                n_np    = i_alu_res;
                n_state = S_SPL4;
            end
            S_SPL4: begin
                o_alu_op      = ALU_SUB;
                o_alu_a       = WW'(r_size);
                o_alu_b       = r_tmp;
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_np[AW-1:0];
                o_mem_wr_data = {1'b1, i_alu_res[AW-1:0]};
                n_split       = 1'b1;
                n_state       = S_ACOM;
            end
            S_ACOM: begin
                o_alu_a        = r_pos;
                o_alu_b        = HDR_V;
                n_res.granted  = i_alu_res[OFF_W-1:0];
                n_res.pad_add  = ALIGN_W'(0) - r_req[ALIGN_W-1:0];
                o_mem_wr_en    = 1'b1;
                o_mem_wr_data  = {1'b0, (r_split ? r_thr[AW-1:0] : r_size)};
                n_state        = S_DONE;
            end
            S_FM1: begin
                o_alu_a = r_pos;
                o_alu_b = WW'(r_size);
                n_tmp   = i_alu_res;
                n_state = S_FM2;
            end
            S_FM2: begin
                o_alu_a = r_tmp;
                o_alu_b = HDR_V;
                n_np    = i_alu_res;
                n_state = S_FM3;
            end
            S_FM3: begin
                o_alu_op = ALU_SUB;
                o_alu_a  = r_np;
                o_alu_b  = POOL_V;
                if (i_alu_lt) begin
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = r_np[AW-1:0];
                    n_state       = S_FM4;
                end else begin
                    // Last block of the pool: nothing follows to merge with.
                    o_mem_wr_en   = 1'b1;
                    o_mem_wr_data = {1'b1, r_size};
                    n_state       = S_DONE;
                end
            end
            S_FM4: begin
                n_nsize = w_rd_size;
                n_nfree = w_rd_free;
                o_alu_a = WW'(r_size);
                o_alu_b = HDR_V;
                n_tmp   = i_alu_res;
                n_state = S_FM5;
            end
            S_FM5: begin
                // The absorbed header is left stale; it is no longer a block start
                // and is rewritten before any walk can reach it again.
                o_alu_a     = r_tmp;
                o_alu_b     = WW'(r_nsize);
                o_mem_wr_en = 1'b1;
                if (r_nfree) begin
                    o_mem_wr_data = {1'b1, i_alu_res[AW-1:0]};
                end else begin
                    o_mem_wr_data = {1'b1, r_size};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_res  = r_res;

endmodule

>>> design/first_fit_pool_allocator_unit.sv
// Top level of the first-fit pool allocator: handshakes, padding counter, result register.
//
// This block manages a byte pool as a chain of blocks, each led by a header that
// holds the payload size and a free mark; the headers live in a RAM with one entry
// per pool byte offset. An allocate walks the chain from offset zero and takes the
// first free block that holds the request rounded up to four bytes, splitting off
// the rest when it exceeds one header; a free checks that the address is a block
// start, marks it free and merges it with the next block when that one is free; a
// gap query counts free blocks smaller than the request plus one header. Every walk
// step runs through one shared add/subtract unit and one RAM read port; the default
// pool is 1024 bytes with 16-byte headers. Input stall stays high while an item is
// in progress and drops as soon as its result moves into the output register, so
// the next item can be taken while that result still waits downstream. After reset
// the block writes the initial header before it accepts its first item. The padding
// total on every result is the running sum of alignment padding after that item,
// saturating at its all-ones value.
module first_fit_pool_allocator_unit import ffpa_pkg::*; #(
    parameter int unsigned POOL_BYTES   = DEF_POOL_BYTES,
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int unsigned AW = f_addr_w(POOL_BYTES);
    localparam int unsigned WW = f_calc_w(POOL_BYTES);

    // Sequencer handshake and result.
    logic             w_idle;
    logic             w_done;
    logic             w_take;
    logic             w_start;
    t_ctrl_res        w_res;

    // Shared arithmetic unit.
    t_alu_op          w_alu_op;
    logic [WW-1:0]    w_alu_a;
    logic [WW-1:0]    w_alu_b;
    logic [WW-1:0]    w_alu_res;
    logic             w_alu_lt;

    // Header RAM.
    logic             w_mem_wr_en;
    logic [AW-1:0]    w_mem_wr_addr;
    logic [AW:0]      w_mem_wr_data;
    logic             w_mem_rd_en;
    logic [AW-1:0]    w_mem_rd_addr;
    logic [AW:0]      w_mem_rd_data;

    // Output register and padding counter.
    logic             r_out_valid;
    t_out_item        r_out_item;
    logic [PAD_W-1:0] r_pad_sum;
    logic [PAD_W:0]   w_pad_wide;
    logic [PAD_W-1:0] w_pad_next;

    // An item is taken only while the sequencer sits idle.
    assign o_in_stall = !w_idle;
    assign w_start    = i_in_valid && w_idle;

    // A finished result moves on when the output register is empty or being drained.
    assign w_take = w_done && (!r_out_valid || !i_out_stall);

    // Padding per allocate is at most three bytes; clamp the running sum at all ones.
    assign w_pad_wide = {1'b0, r_pad_sum} + (PAD_W + 1)'(w_res.pad_add);
    assign w_pad_next = w_pad_wide[PAD_W] ? PAD_MAX : w_pad_wide[PAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pad_sum   <= '0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_pad_sum   <= w_pad_next;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_item.status         <= w_res.status;
            r_out_item.granted_offset <= w_res.granted;
            r_out_item.gap_count      <= w_res.gaps;
            r_out_item.padding_total  <= w_pad_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    ffpa_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_item        (i_in_item),
        .o_idle        (w_idle),
        .o_done        (w_done),
        .i_take        (w_take),
        .o_res         (w_res),
        .o_alu_op      (w_alu_op),
        .o_alu_a       (w_alu_a),
        .o_alu_b       (w_alu_b),
        .i_alu_res     (w_alu_res),
        .i_alu_lt      (w_alu_lt),
        .o_mem_wr_en   (w_mem_wr_en),
        .o_mem_wr_addr (w_mem_wr_addr),
        .o_mem_wr_data (w_mem_wr_data),
        .o_mem_rd_en   (w_mem_rd_en),
        .o_mem_rd_addr (w_mem_rd_addr),
        .i_mem_rd_data (w_mem_rd_data)
    );

    ffpa_alu #(
        .WIDTH (WW)
    ) u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res),
        .o_lt  (w_alu_lt)
    );

    ffpa_ram #(
        .WIDTH (AW + 1),
        .DEPTH (POOL_BYTES)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_wr_en),
        .i_wr_addr (w_mem_wr_addr),
        .i_wr_data (w_mem_wr_data),
        .i_rd_en   (w_mem_rd_en),
        .i_rd_addr (w_mem_rd_addr),
        .o_rd_data (w_mem_rd_data)
    );

endmodule
